// ===== sv/rle_esc_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_esc_pkg: shared types and constants of the escape run-length decoder
// Holds the escape marks, the mode encoding, the channel payloads and the
// decode state and step result records.
// ----------------------------------------------------------------------------
package rle_esc_pkg;

  // Escape marks
  localparam logic [7:0] MARK_A = 8'h81;
  localparam logic [7:0] MARK_B = 8'h82;

  // Escape mode; code 3 is unused and decodes as plain
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_A     = 2'd1,
    MODE_AB    = 2'd2
  } esc_mode_t;

  // Input item
  typedef struct packed {
    logic       start_stream;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item: one run descriptor
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] repeat_res;
    logic       last_of_item;
    logic       stream_done;
  } out_item_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    esc_mode_t   mode;
    logic [7:0]  saved_byte;
    logic [31:0] remaining;
  } dec_state_t;

  // Outcome of decoding one byte
  typedef struct packed {
    dec_state_t state_nxt;
    logic [1:0] res_cnt;
    out_item_t  res0;
    out_item_t  res1;
  } step_t;

endpackage

// ===== sv/rle_esc_chan_if.sv =====
// ----------------------------------------------------------------------------
// rle_esc_chan_if: valid/ready channel
// One transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface rle_esc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rle_esc_core.sv =====
// ----------------------------------------------------------------------------
// rle_esc_core: single-byte decode step
// Computes the next decoder state and up to two run descriptors from the
// current state, one input item and the configured output length.
// ----------------------------------------------------------------------------
module rle_esc_core (
  input  rle_esc_pkg::dec_state_t state,
  input  rle_esc_pkg::in_item_t   item,
  input  logic [31:0]             out_len,
  output rle_esc_pkg::step_t      step
);

  logic [7:0]  ch;
  logic [31:0] rem0;
  logic [31:0] rem_m1;
  logic [31:0] rem_m2;
  logic [7:0]  rep_raw;
  logic [7:0]  rep;
  rle_esc_pkg::esc_mode_t mode0;

  assign ch      = item.data_byte;
  assign rem0    = item.start_stream ? out_len : state.remaining;
  assign mode0   = item.start_stream ? rle_esc_pkg::MODE_PLAIN : state.mode;
  assign rem_m1  = rem0 - 32'd1;
  assign rem_m2  = rem0 - 32'd2;
  assign rep_raw = ch - 8'd1;
  // Clip the repeat to the remaining count
  assign rep     = (rem0 < {24'd0, rep_raw}) ? rem0[7:0] : rep_raw;

  always_comb begin
    step                    = '0;
    step.state_nxt.mode       = mode0;
    step.state_nxt.saved_byte = state.saved_byte;
    step.state_nxt.remaining  = rem0;

    // Drop the byte once the count is exhausted
    if (rem0 != 32'd0) begin
      unique case (mode0)
        rle_esc_pkg::MODE_A: begin
          if (ch == rle_esc_pkg::MARK_B) begin
            step.state_nxt.mode = rle_esc_pkg::MODE_AB;
          end else begin
            // Lone first mark becomes a literal
            step.state_nxt.saved_byte = rle_esc_pkg::MARK_A;
            step.state_nxt.remaining  = rem_m1;
            step.res_cnt              = 2'd1;
            step.res0.value           = rle_esc_pkg::MARK_A;
            step.res0.repeat_res      = 8'd1;
            step.res0.stream_done     = (rem_m1 == 32'd0);
            if (rem_m1 != 32'd0 && !(ch == rle_esc_pkg::MARK_A && rem_m1 != 32'd1)) begin
              step.state_nxt.mode       = rle_esc_pkg::MODE_PLAIN;
              step.state_nxt.saved_byte = ch;
              step.state_nxt.remaining  = rem_m2;
              step.res_cnt              = 2'd2;
              step.res1.value           = ch;
              step.res1.repeat_res      = 8'd1;
              step.res1.stream_done     = (rem_m2 == 32'd0);
            end
          end
        end
        rle_esc_pkg::MODE_AB: begin
          step.state_nxt.mode = rle_esc_pkg::MODE_PLAIN;
          if (ch != 8'd0) begin
            // Repeat the last literal; a count of one adds nothing
            if (rep != 8'd0) begin
              step.state_nxt.remaining = rem0 - {24'd0, rep};
              step.res_cnt             = 2'd1;
              step.res0.value          = state.saved_byte;
              step.res0.repeat_res     = rep;
              step.res0.stream_done    = (rem0 == {24'd0, rep});
            end
          end else begin
            // Escaped literal pair
            step.state_nxt.remaining = rem_m1;
            step.res_cnt             = 2'd1;
            step.res0.value          = rle_esc_pkg::MARK_A;
            step.res0.repeat_res     = 8'd1;
            step.res0.stream_done    = (rem_m1 == 32'd0);
            if (rem_m1 != 32'd0) begin
              step.state_nxt.saved_byte = rle_esc_pkg::MARK_B;
              step.state_nxt.remaining  = rem_m2;
              step.res_cnt              = 2'd2;
              step.res1.value           = rle_esc_pkg::MARK_B;
              step.res1.repeat_res      = 8'd1;
              step.res1.stream_done     = (rem_m2 == 32'd0);
            end
          end
        end
        default: begin
          step.state_nxt.mode = rle_esc_pkg::MODE_PLAIN;
          if (ch == rle_esc_pkg::MARK_A && rem0 != 32'd1) begin
            step.state_nxt.mode = rle_esc_pkg::MODE_A;
          end else begin
            step.state_nxt.saved_byte = ch;
            step.state_nxt.remaining  = rem_m1;
            step.res_cnt              = 2'd1;
            step.res0.value           = ch;
            step.res0.repeat_res      = 8'd1;
            step.res0.stream_done     = (rem_m1 == 32'd0);
          end
        end
      endcase
    end

    // Flag the final result of this byte
    step.res0.last_of_item = (step.res_cnt == 2'd1);
    step.res1.last_of_item = 1'b1;
  end

endmodule

// ===== sv/rle_esc_outq.sv =====
// ----------------------------------------------------------------------------
// rle_esc_outq: two-entry result register
// Takes up to two run descriptors per cycle and presents them one transfer
// at a time on the result channel; reports the free slots after this
// cycle's transfer.
// ----------------------------------------------------------------------------
module rle_esc_outq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               push_cnt,
  input  rle_esc_pkg::out_item_t   push0,
  input  rle_esc_pkg::out_item_t   push1,
  output logic [1:0]               free,
  rle_esc_chan_if.source           out_ch
);

  logic [1:0]             cnt_r;
  logic [1:0]             cnt_nxt;
  logic [1:0]             base;
  logic                   pop;
  rle_esc_pkg::out_item_t q_r   [2];
  rle_esc_pkg::out_item_t q_nxt [2];

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data  = q_r[0];
  assign pop          = out_ch.valid && out_ch.ready;
  assign base         = cnt_r - {1'b0, pop};
  assign free         = 2'd2 - base;
  assign cnt_nxt      = base + push_cnt;

  // Advance the head, then append new results behind what stays
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push_cnt != 2'd0) begin
      q_nxt[base[0]] = push0;
    end
    if (push_cnt == 2'd2) begin
      q_nxt[1] = push1;
    end
  end

  // Hold the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload slots need no reset
  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

endmodule

// ===== sv/rle_escape_run_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_escape_run_decoder: escape run-length decoder (0x81 0x82 scheme)
// in_ch carries one compressed byte per transfer with a start_stream flag
// that reloads the output count from the output_length register and clears
// the escape mode. out_ch carries run descriptors (value, repeat_res) with
// last_of_item on the final run of each byte and stream_done once the count
// is used up. cfg_ch writes output_length and is always ready; it must be
// written only while the decoder is idle, which the block does not enforce.
// A byte accepted on in_ch is held in the input register, decoded from it,
// and its runs are registered in the result register before they reach out_ch.
// Throughput: one byte per cycle while each byte gives at most one run and
// out_ch is not stalled; a byte that gives two runs fills both entries of
// the result register. Bytes that give no run still take a decode step.
// Reset clears the escape mode, last literal, remaining count, output_length
// and all valid flags. When the receiver stalls, results wait in the result
// register; the input register keeps taking bytes until it holds one that
// cannot be decoded for lack of result slots, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module rle_escape_run_decoder (
  input  logic            clk,
  input  logic            rst_n,
  rle_esc_chan_if.sink    in_ch,
  rle_esc_chan_if.source  out_ch,
  rle_esc_chan_if.sink    cfg_ch
);

  logic                    inv_r;
  logic                    inv_nxt;
  rle_esc_pkg::in_item_t   in_r;
  logic [31:0]             out_len_r;
  rle_esc_pkg::dec_state_t st_r;
  rle_esc_pkg::step_t      step;
  logic [1:0]              free;
  logic                    proc;
  logic [1:0]              push_cnt;

  // Configuration register is always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r <= 32'd0;
    end else if (cfg_ch.valid) begin
      out_len_r <= cfg_ch.data;
    end
  end

  // Decode the held byte
  rle_esc_core u_core (
    .state   (st_r),
    .item    (in_r),
    .out_len (out_len_r),
    .step    (step)
  );

  // Advance only when its results fit behind what stays in the result register
  assign proc     = inv_r && (step.res_cnt <= free);
  assign push_cnt = proc ? step.res_cnt : 2'd0;

  assign in_ch.ready = !inv_r || proc;
  assign inv_nxt     = in_ch.valid || (inv_r && !proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else begin
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= rle_esc_pkg::MODE_PLAIN;
      st_r.saved_byte <= 8'd0;
      st_r.remaining  <= 32'd0;
    end else if (proc) begin
      st_r <= step.state_nxt;
    end
  end

  // Result register
  rle_esc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (step.res0),
    .push1    (step.res1),
    .free     (free),
    .out_ch   (out_ch)
  );

endmodule
